/* design/cog2x_pkg.sv */
package cog2x_pkg;

	// Low nibble of the opcode within the 0x20-0x2F group
	typedef enum logic [3:0] {
		OP_JR_NZ   = 4'h0,
		OP_LD_HL16 = 4'h1,
		OP_ST_HLI  = 4'h2,
		OP_INC_HL  = 4'h3,
		OP_INC_H   = 4'h4,
		OP_DEC_H   = 4'h5,
		OP_LD_H8   = 4'h6,
		OP_DAA     = 4'h7,
		OP_JR_Z    = 4'h8,
		OP_ADD_HL  = 4'h9,
		OP_LD_AHLI = 4'hA,
		OP_DEC_HL  = 4'hB,
		OP_INC_L   = 4'hC,
		OP_DEC_L   = 4'hD,
		OP_LD_L8   = 4'hE,
		OP_CPL     = 4'hF
	} op_t;

	// Flag bit positions in the 4-bit flag word
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [3:0] CYC_SHORT = 4'd4;
	localparam logic [3:0] CYC_MID   = 4'd8;
	localparam logic [3:0] CYC_LONG  = 4'd12;

	localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
	localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
	localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ   = 8'h06;

	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  acc;
		logic [7:0]  high;
		logic [7:0]  low;
		logic [3:0]  flags;
	} arch_t;

	typedef struct packed {
		arch_t       state;
		logic        write_enable;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [3:0]  cycle_count;
	} exec_res_t;

endpackage

/* design/cog2x_exec.sv */
module cog2x_exec (
	input  logic [3:0]           kind,
	input  logic [15:0]          immediate,
	input  logic [7:0]           read_data,
	input  cog2x_pkg::arch_t     cur,
	output cog2x_pkg::exec_res_t res
);

	logic [15:0] hl;
	logic [15:0] hl_inc;
	logic [15:0] hl_dec;
	logic [15:0] hl_dbl;
	logic [7:0]  d8;
	logic [15:0] offset;
	logic [15:0] pc_p1;
	logic [15:0] pc_p2;
	logic [15:0] pc_p3;
	logic [7:0]  daa_a;
	logic        daa_c;
	logic [7:0]  daa_pre;
	logic        zflag;

	assign hl     = {cur.high, cur.low};
	assign hl_inc = hl + 16'd1;
	assign hl_dec = hl - 16'd1;
	assign hl_dbl = {hl[14:0], 1'b0};
	assign d8     = immediate[7:0];
	assign offset = {{8{d8[7]}}, d8};
	assign pc_p1  = cur.pc + 16'd1;
	assign pc_p2  = cur.pc + 16'd2;
	assign pc_p3  = cur.pc + 16'd3;
	assign zflag  = cur.flags[cog2x_pkg::FLAG_Z];

	// Decimal adjust; the upper correction leaves the low nibble untouched
	always_comb begin
		daa_pre = cur.acc;
		daa_c   = cur.flags[cog2x_pkg::FLAG_C];
		if (!cur.flags[cog2x_pkg::FLAG_N]) begin
			if (cur.flags[cog2x_pkg::FLAG_C] || (cur.acc > cog2x_pkg::DAA_HI_LIMIT)) begin
				daa_pre = cur.acc + cog2x_pkg::DAA_HI_ADJ;
				daa_c   = 1'b1;
			end
			if (cur.flags[cog2x_pkg::FLAG_H] || (cur.acc[3:0] > cog2x_pkg::DAA_LO_LIMIT)) begin
				daa_a = daa_pre + cog2x_pkg::DAA_LO_ADJ;
			end else begin
				daa_a = daa_pre;
			end
		end else begin
			if (cur.flags[cog2x_pkg::FLAG_C]) begin
				daa_pre = cur.acc - cog2x_pkg::DAA_HI_ADJ;
			end
			if (cur.flags[cog2x_pkg::FLAG_H]) begin
				daa_a = daa_pre - cog2x_pkg::DAA_LO_ADJ;
			end else begin
				daa_a = daa_pre;
			end
		end
	end

	always_comb begin
		res               = '0;
		res.state         = cur;
		res.state.pc      = pc_p1;
		res.cycle_count   = cog2x_pkg::CYC_SHORT;
		unique case (cog2x_pkg::op_t'(kind))
			cog2x_pkg::OP_JR_NZ, cog2x_pkg::OP_JR_Z: begin
				// JR Z taken when Z set, JR NZ when clear
				if (zflag == (kind == cog2x_pkg::OP_JR_Z)) begin
					res.state.pc    = pc_p2 + offset;
					res.cycle_count = cog2x_pkg::CYC_LONG;
				end else begin
					res.state.pc    = pc_p2;
					res.cycle_count = cog2x_pkg::CYC_MID;
				end
			end
			cog2x_pkg::OP_LD_HL16: begin
				{res.state.high, res.state.low} = immediate;
				res.state.pc    = pc_p3;
				res.cycle_count = cog2x_pkg::CYC_LONG;
			end
			cog2x_pkg::OP_ST_HLI: begin
				res.write_enable  = 1'b1;
				res.write_address = hl;
				res.write_data    = cur.acc;
				{res.state.high, res.state.low} = hl_inc;
				res.cycle_count   = cog2x_pkg::CYC_MID;
			end
			cog2x_pkg::OP_INC_HL: begin
				{res.state.high, res.state.low} = hl_inc;
				res.cycle_count = cog2x_pkg::CYC_MID;
			end
			cog2x_pkg::OP_INC_H: begin
				res.state.high = cur.high + 8'd1;
				res.state.flags[cog2x_pkg::FLAG_H] = (cur.high[3:0] == 4'hF);
				res.state.flags[cog2x_pkg::FLAG_N] = 1'b0;
				res.state.flags[cog2x_pkg::FLAG_Z] = (cur.high == 8'hFF);
			end
			cog2x_pkg::OP_DEC_H: begin
				res.state.high = cur.high - 8'd1;
				res.state.flags[cog2x_pkg::FLAG_H] = (cur.high[3:0] == 4'h0);
				res.state.flags[cog2x_pkg::FLAG_N] = 1'b1;
				res.state.flags[cog2x_pkg::FLAG_Z] = (cur.high == 8'h01);
			end
			cog2x_pkg::OP_LD_H8: begin
				res.state.high  = d8;
				res.state.pc    = pc_p2;
				res.cycle_count = cog2x_pkg::CYC_MID;
			end
			cog2x_pkg::OP_DAA: begin
				res.state.acc = daa_a;
				res.state.flags[cog2x_pkg::FLAG_Z] = (daa_a == 8'h00);
				res.state.flags[cog2x_pkg::FLAG_H] = 1'b0;
				res.state.flags[cog2x_pkg::FLAG_C] = daa_c;
			end
			cog2x_pkg::OP_ADD_HL: begin
				{res.state.high, res.state.low} = hl_dbl;
				res.state.flags[cog2x_pkg::FLAG_N] = 1'b0;
				res.state.flags[cog2x_pkg::FLAG_H] = hl[11];
				res.state.flags[cog2x_pkg::FLAG_C] = hl[15];
				res.cycle_count = cog2x_pkg::CYC_MID;
			end
			cog2x_pkg::OP_LD_AHLI: begin
				res.state.acc = read_data;
				{res.state.high, res.state.low} = hl_inc;
				res.cycle_count = cog2x_pkg::CYC_MID;
			end
			cog2x_pkg::OP_DEC_HL: begin
				{res.state.high, res.state.low} = hl_dec;
				res.cycle_count = cog2x_pkg::CYC_MID;
			end
			cog2x_pkg::OP_INC_L: begin
				res.state.low = cur.low + 8'd1;
				res.state.flags[cog2x_pkg::FLAG_H] = (cur.low[3:0] == 4'hF);
				res.state.flags[cog2x_pkg::FLAG_N] = 1'b0;
				res.state.flags[cog2x_pkg::FLAG_Z] = (cur.low == 8'hFF);
			end
			cog2x_pkg::OP_DEC_L: begin
				res.state.low = cur.low - 8'd1;
				res.state.flags[cog2x_pkg::FLAG_H] = (cur.low[3:0] == 4'h0);
				res.state.flags[cog2x_pkg::FLAG_N] = 1'b1;
				res.state.flags[cog2x_pkg::FLAG_Z] = (cur.low == 8'h01);
			end
			cog2x_pkg::OP_LD_L8: begin
				res.state.low   = d8;
				res.state.pc    = pc_p2;
				res.cycle_count = cog2x_pkg::CYC_MID;
			end
			cog2x_pkg::OP_CPL: begin
				res.state.acc = ~cur.acc;
				res.state.flags[cog2x_pkg::FLAG_N] = 1'b1;
				res.state.flags[cog2x_pkg::FLAG_H] = 1'b1;
			end
		endcase
	end

endmodule

/* design/cpu_opcode_group_2x_execute.sv */
// Executes CPU opcodes 0x20-0x2F (JR NZ/Z, LD HL,d16, LD (HL+),A, LD A,(HL+),
// INC/DEC HL/H/L, LD H/L,d8, ADD HL,HL, DAA, CPL), one per item.
// Input channel: item_valid/item_ready carry kind (opcode low nibble),
// immediate (operand bytes) and read_data (byte at HL for LD A,(HL+)).
// Result channel: result_valid/result_ready carry the registers after the
// instruction (pc_out, acc_out, high_out, low_out, flags_out), the memory
// store request (write_enable, write_address, write_data) and cycle_count.
// Path: an accepted item is held in an input register, executed through
// one combinational pass, and lands in the result register together with
// the architectural state, at which point result_valid rises.
// Throughput: one item per cycle unless the receiver stalls; the next item
// sees the state the previous one left because state and result register
// load on the same edge.
// Reset (arst_n low): PC, A, H, L and flags clear to zero, both stages empty.
// Receiver stall: the result register holds; the input register still takes
// one more item, then item_ready drops until the result is taken.
module cpu_opcode_group_2x_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [3:0]  kind,
	input  logic [15:0] immediate,
	input  logic [7:0]  read_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] pc_out,
	output logic [7:0]  acc_out,
	output logic [7:0]  high_out,
	output logic [7:0]  low_out,
	output logic [3:0]  flags_out,
	output logic        write_enable,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic [3:0]  cycle_count
);

	// Input stage
	logic                 valid_s1;
	logic [3:0]           kind_s1;
	logic [15:0]          imm_s1;
	logic [7:0]           rd_s1;

	// Architectural registers and result register
	cog2x_pkg::arch_t     arch_q;
	cog2x_pkg::exec_res_t res_q;
	logic                 res_valid_q;

	cog2x_pkg::exec_res_t exec_res;
	logic                 advance;

	// Execute when the result slot is free or is being drained this cycle
	assign advance    = valid_s1 && (!res_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload of the input stage: hold while stalled
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			kind_s1 <= kind;
			imm_s1  <= immediate;
			rd_s1   <= read_data;
		end
	end

	cog2x_exec u_exec (
		.kind      (kind_s1),
		.immediate (imm_s1),
		.read_data (rd_s1),
		.cur       (arch_q),
		.res       (exec_res)
	);

	// Commit state only when the instruction moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				arch_q <= exec_res.state;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= exec_res;
		end
	end

	assign result_valid  = res_valid_q;
	assign pc_out        = res_q.state.pc;
	assign acc_out       = res_q.state.acc;
	assign high_out      = res_q.state.high;
	assign low_out       = res_q.state.low;
	assign flags_out     = res_q.state.flags;
	assign write_enable  = res_q.write_enable;
	assign write_address = res_q.write_address;
	assign write_data    = res_q.write_data;
	assign cycle_count   = res_q.cycle_count;

endmodule

/* design/cog2x_checker.sv */
module cog2x_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] write_address,
	input logic [7:0]  write_data,
	input logic        write_enable,
	input logic [3:0]  cycle_count
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// An empty result slot never blocks the input
	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty result slot");

	a_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (cycle_count == 4'd4 || cycle_count == 4'd8 ||
			cycle_count == 4'd12))
		else $error("bad cycle count");

	// Only the store instruction drives the bus; its cycle_count is always 8
	a_store: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && write_enable |-> cycle_count == 4'd8)
		else $error("store with wrong cycle count");

	a_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !write_enable |-> write_address == 16'd0 && write_data == 8'd0)
		else $error("write bus not cleared");

endmodule

bind cpu_opcode_group_2x_execute cog2x_checker u_cog2x_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_ready    (item_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.write_address (write_address),
	.write_data    (write_data),
	.write_enable  (write_enable),
	.cycle_count   (cycle_count)
);

/* verif/cpu_opcode_group_2x_execute_test.sv */
module cpu_opcode_group_2x_execute_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 40;

	// Architectural shadow of the core: tracks PC, A, H, L and flags for every
	// accepted opcode and keeps the retire records still owed by the block.
	class retire_board;
		logic [15:0]          pc;
		logic [7:0]           acc;
		logic [7:0]           hi;
		logic [7:0]           lo;
		logic [3:0]           flags;
		cog2x_pkg::exec_res_t retire_queue[$];
		int                   mismatches;
		int                   checked;

		function new();
			pc = '0;
			acc = '0;
			hi = '0;
			lo = '0;
			flags = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function int pending();
			return retire_queue.size();
		endfunction

		// 8-bit INC/DEC on H or L: carry flag untouched, H is the nibble carry/borrow
		function logic [7:0] step8(logic [7:0] v, bit down);
			logic [7:0] r;
			r = down ? v - 8'd1 : v + 8'd1;
			flags[cog2x_pkg::FLAG_H] = down ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF);
			flags[cog2x_pkg::FLAG_N] = down;
			flags[cog2x_pkg::FLAG_Z] = (r == 8'h00);
			return r;
		endfunction

		function void note_item(cog2x_pkg::op_t op, logic [15:0] imm, logic [7:0] rd);
			cog2x_pkg::exec_res_t r;
			logic [15:0]          hl;
			logic [15:0]          next_pc;
			logic [7:0]           d8;
			logic [7:0]           a;
			logic                 take;
			hl = {hi, lo};
			d8 = imm[7:0];
			next_pc = pc + 16'd1;
			r.write_enable = 1'b0;
			r.write_address = '0;
			r.write_data = '0;
			r.cycle_count = 4'd4;
			case (op)
				cog2x_pkg::OP_JR_NZ, cog2x_pkg::OP_JR_Z: begin
					take = (op == cog2x_pkg::OP_JR_Z) ? flags[cog2x_pkg::FLAG_Z]
						: !flags[cog2x_pkg::FLAG_Z];
					next_pc = pc + 16'd2;
					if (take) begin
						next_pc = next_pc + {{8{d8[7]}}, d8};
						r.cycle_count = 4'd12;
					end else begin
						r.cycle_count = 4'd8;
					end
				end
				cog2x_pkg::OP_LD_HL16: begin
					{hi, lo} = imm;
					next_pc = pc + 16'd3;
					r.cycle_count = 4'd12;
				end
				cog2x_pkg::OP_ST_HLI: begin
					r.write_enable = 1'b1;
					r.write_address = hl;
					r.write_data = acc;
					{hi, lo} = hl + 16'd1;
					r.cycle_count = 4'd8;
				end
				cog2x_pkg::OP_INC_HL: begin
					{hi, lo} = hl + 16'd1;
					r.cycle_count = 4'd8;
				end
				cog2x_pkg::OP_INC_H: hi = step8(hi, 1'b0);
				cog2x_pkg::OP_DEC_H: hi = step8(hi, 1'b1);
				cog2x_pkg::OP_LD_H8: begin
					hi = d8;
					next_pc = pc + 16'd2;
					r.cycle_count = 4'd8;
				end
				cog2x_pkg::OP_DAA: begin
					a = acc;
					if (!flags[cog2x_pkg::FLAG_N]) begin
						if (flags[cog2x_pkg::FLAG_C] || a > 8'h99) begin
							a = a + 8'h60;
							flags[cog2x_pkg::FLAG_C] = 1'b1;
						end
						if (flags[cog2x_pkg::FLAG_H] || a[3:0] > 4'h9)
							a = a + 8'h06;
					end else begin
						if (flags[cog2x_pkg::FLAG_C])
							a = a - 8'h60;
						if (flags[cog2x_pkg::FLAG_H])
							a = a - 8'h06;
					end
					acc = a;
					flags[cog2x_pkg::FLAG_Z] = (a == 8'h00);
					flags[cog2x_pkg::FLAG_H] = 1'b0;
				end
				cog2x_pkg::OP_ADD_HL: begin
					flags[cog2x_pkg::FLAG_N] = 1'b0;
					flags[cog2x_pkg::FLAG_H] = hl[11];
					flags[cog2x_pkg::FLAG_C] = hl[15];
					{hi, lo} = {hl[14:0], 1'b0};
					r.cycle_count = 4'd8;
				end
				cog2x_pkg::OP_LD_AHLI: begin
					acc = rd;
					{hi, lo} = hl + 16'd1;
					r.cycle_count = 4'd8;
				end
				cog2x_pkg::OP_DEC_HL: begin
					{hi, lo} = hl - 16'd1;
					r.cycle_count = 4'd8;
				end
				cog2x_pkg::OP_INC_L: lo = step8(lo, 1'b0);
				cog2x_pkg::OP_DEC_L: lo = step8(lo, 1'b1);
				cog2x_pkg::OP_LD_L8: begin
					lo = d8;
					next_pc = pc + 16'd2;
					r.cycle_count = 4'd8;
				end
				default: begin
					acc = ~acc;
					flags[cog2x_pkg::FLAG_N] = 1'b1;
					flags[cog2x_pkg::FLAG_H] = 1'b1;
				end
			endcase
			pc = next_pc;
			r.state.pc = pc;
			r.state.acc = acc;
			r.state.high = hi;
			r.state.low = lo;
			r.state.flags = flags;
			retire_queue.push_back(r);
		endfunction

		task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
			if (mismatches < PRINT_CAP)
				$display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
					$realtime, checked, what, got, want);
			mismatches++;
		endtask

		task check_field(string what, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		task check_result(cog2x_pkg::exec_res_t got);
			cog2x_pkg::exec_res_t want;
			if (retire_queue.size() == 0) begin
				report_mismatch("unexpected result, pc_out", got.state.pc, 16'h0);
			end else begin
				want = retire_queue.pop_front();
				check_field("pc_out", got.state.pc, want.state.pc);
				check_field("acc_out", 16'(got.state.acc), 16'(want.state.acc));
				check_field("high_out", 16'(got.state.high), 16'(want.state.high));
				check_field("low_out", 16'(got.state.low), 16'(want.state.low));
				check_field("flags_out", 16'(got.state.flags), 16'(want.state.flags));
				check_field("write_enable", 16'(got.write_enable),
					16'(want.write_enable));
				check_field("write_address", got.write_address, want.write_address);
				check_field("write_data", 16'(got.write_data), 16'(want.write_data));
				check_field("cycle_count", 16'(got.cycle_count), 16'(want.cycle_count));
			end
			checked++;
		endtask
	endclass

	// Drive every input to a known value from time zero; hold reset low.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [3:0]  kind = '0;
	logic [15:0] immediate = '0;
	logic [7:0]  read_data = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [15:0] pc_out;
	logic [7:0]  acc_out;
	logic [7:0]  high_out;
	logic [7:0]  low_out;
	logic [3:0]  flags_out;
	logic        write_enable;
	logic [15:0] write_address;
	logic [7:0]  write_data;
	logic [3:0]  cycle_count;

	// Percent chance per item (sender) or per cycle (receiver) of starting an
	// idle burst; zero means a clean back-to-back stretch.
	int idle_pct = 0;
	// Cycles of receiver hold-off requested by the stimulus; the receiver
	// picks this up and counts it down on its own.
	int holdoff_request = 0;

	retire_board board;

	cpu_opcode_group_2x_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.kind(kind),
		.immediate(immediate),
		.read_data(read_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.pc_out(pc_out),
		.acc_out(acc_out),
		.high_out(high_out),
		.low_out(low_out),
		.flags_out(flags_out),
		.write_enable(write_enable),
		.write_address(write_address),
		.write_data(write_data),
		.cycle_count(cycle_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one opcode, optionally after an idle burst, and hold it until the
	// block takes it. The shadow model advances only at the accepting edge.
	task automatic issue(cog2x_pkg::op_t op, logic [15:0] imm, logic [7:0] rd);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= op;
		immediate <= imm;
		read_data <= rd;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		board.note_item(op, imm, rd);
	endtask

	// Receiver: check every accepted result, then pick next cycle's ready.
	// A requested hold-off wins over random stalls.
	initial begin : result_side
		cog2x_pkg::exec_res_t got;
		int stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				got = {pc_out, acc_out, high_out, low_out, flags_out,
					write_enable, write_address, write_data, cycle_count};
				board.check_result(got);
			end
			if (holdoff_request > 0) begin
				stall_left = holdoff_request;
				holdoff_request = 0;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				result_ready <= 1'b0;
				stall_left = $urandom_range(0, 9);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Watchdog: give up well past the slowest legal run.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** cpu_opcode_group_2x_execute: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int n;
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: wrap HL both ways, store/load through HL+, nibble carries
		// and borrows on H and L, both jump conditions taken and not taken with
		// extreme offsets, ADD HL,HL carries, DAA on both add and subtract paths.
		idle_pct = 20;
		issue(cog2x_pkg::OP_LD_HL16, 16'hFFFF, 8'h00);
		issue(cog2x_pkg::OP_INC_HL, 16'h0000, 8'hFF);
		issue(cog2x_pkg::OP_DEC_HL, 16'hFFFF, 8'h00);
		issue(cog2x_pkg::OP_ST_HLI, 16'h0000, 8'h5A);
		issue(cog2x_pkg::OP_LD_AHLI, 16'hFFFF, 8'hFF);
		issue(cog2x_pkg::OP_ST_HLI, 16'h1234, 8'h00);
		issue(cog2x_pkg::OP_CPL, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_DAA, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_LD_H8, 16'hAB0F, 8'h00);
		issue(cog2x_pkg::OP_INC_H, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_LD_L8, 16'h5400, 8'h00);
		issue(cog2x_pkg::OP_DEC_L, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_INC_L, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_JR_Z, 16'h0080, 8'h00);
		issue(cog2x_pkg::OP_JR_NZ, 16'hFF7F, 8'h00);
		issue(cog2x_pkg::OP_DEC_H, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_JR_NZ, 16'h007F, 8'h00);
		issue(cog2x_pkg::OP_JR_Z, 16'h00FF, 8'h00);
		issue(cog2x_pkg::OP_LD_HL16, 16'h8800, 8'h00);
		issue(cog2x_pkg::OP_ADD_HL, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_ADD_HL, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_LD_AHLI, 16'h0000, 8'h9A);
		issue(cog2x_pkg::OP_DAA, 16'h0000, 8'h00);
		issue(cog2x_pkg::OP_LD_H8, 16'h0001, 8'h00);
		issue(cog2x_pkg::OP_DEC_H, 16'h0000, 8'h00);

		// Random: uniform opcodes with full-range operands; idling changes every
		// hundred items and stops for the tail of the run.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
				if (n >= RANDOM_ITEMS - 300)
					idle_pct = 0;
			end
			// Stall the receiver for a long stretch while items keep coming,
			// so the block fills and backs up its input.
			if (n == 400)
				holdoff_request = 150;
			// Drain: hold off the sender until every result is back.
			if (n == 800) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (board.pending() != 0)
					@(posedge clk);
			end
			issue(cog2x_pkg::op_t'($urandom_range(0, 15)), 16'($urandom), 8'($urandom));
		end
		item_valid <= 1'b0;

		// Wait out the tail, then a few more edges to catch stray results.
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0)
			$display("** cpu_opcode_group_2x_execute: PASSED **");
		else
			$display("** cpu_opcode_group_2x_execute: FAILED **");
		$finish;
	end

endmodule
